FILE: design/bresenham_line_pixel_stepper_core_macros.svh
// assertion helpers shared by the line stepper
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_CORE_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define BLS_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("line stepper check failed");

// next-cycle implication, off during reset
`define BLS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("line stepper check failed");

`endif

FILE: design/bls_pkg.sv
package bls_pkg;

  localparam int unsigned COLOR_BITS = 16;

  // item kinds carried on the input tuser
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // five pixels on, five off
  localparam logic [3:0] DASH_PERIOD = 4'd10;
  localparam logic [3:0] DASH_ON_MAX = 4'd4;

  typedef struct packed {
    logic active;
    logic line_dashed;
  } bls_status_t;

endpackage

FILE: design/bls_step.sv
module bls_step #(
  parameter int unsigned COORD_BITS = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  // input item
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [COORD_BITS-1:0]          in_start_x,
  input  logic [COORD_BITS-1:0]          in_start_y,
  input  logic [COORD_BITS-1:0]          in_end_x,
  input  logic [COORD_BITS-1:0]          in_end_y,
  input  logic [bls_pkg::COLOR_BITS-1:0] in_color,
  input  logic                           in_dashed,
  // result slot
  input  logic                           take,
  output logic                           res_valid,
  output logic [COORD_BITS-1:0]          res_x,
  output logic [COORD_BITS-1:0]          res_y,
  output logic [bls_pkg::COLOR_BITS-1:0] res_color,
  output logic                           res_draw,
  output logic                           res_last,
  output bls_pkg::bls_status_t           status
);
  import bls_pkg::*;

  localparam int unsigned CNT_W = COORD_BITS + 1;
  localparam int unsigned ERR_W = COORD_BITS + 3;
  localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
  localparam logic [CNT_W-1:0]      CNT_ONE   = CNT_W'(1);

  // item register
  logic                  item_valid;
  logic                  item_mode;
  logic [COORD_BITS-1:0] item_sx;
  logic [COORD_BITS-1:0] item_sy;
  logic [COORD_BITS-1:0] item_ex;
  logic [COORD_BITS-1:0] item_ey;
  logic [COLOR_BITS-1:0] item_color;
  logic                  item_dashed;

  // line state
  logic                  active;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [ERR_W-1:0]      err_term;
  logic [CNT_W-1:0]      major_len;
  logic [CNT_W-1:0]      minor_len;
  logic [CNT_W-1:0]      step_count;
  logic                  steep;
  logic                  x_down;
  logic                  y_down;
  logic [3:0]            dash_phase;
  logic [COLOR_BITS-1:0] pen_color;
  logic                  line_dashed;

  logic                  adv;
  logic                  do_start;
  logic                  do_step;

  // setup terms
  logic                  su_x_down;
  logic                  su_y_down;
  logic [COORD_BITS-1:0] su_adx;
  logic [COORD_BITS-1:0] su_ady;
  logic                  su_steep;
  logic [COORD_BITS-1:0] su_major;
  logic [COORD_BITS-1:0] su_minor;
  logic [ERR_W-1:0]      su_err;

  // step terms
  logic                  err_nonneg;
  logic                  is_last;
  logic [ERR_W-1:0]      err_next;
  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;
  logic [3:0]            dash_phase_next;

  function automatic logic [COORD_BITS-1:0] move_coord(
    input logic [COORD_BITS-1:0] v,
    input logic                  down
  );
    return down ? (v - COORD_ONE) : (v + COORD_ONE);
  endfunction

  assign adv      = item_valid && take;
  assign in_ready = !item_valid || take;
  assign do_start = adv && (item_mode == MODE_START);
  assign do_step  = adv && (item_mode == MODE_STEP) && active;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_mode   <= in_mode;
      item_sx     <= in_start_x;
      item_sy     <= in_start_y;
      item_ex     <= in_end_x;
      item_ey     <= in_end_y;
      item_color  <= in_color;
      item_dashed <= in_dashed;
    end
  end

  always_comb begin
    su_x_down = item_ex < item_sx;
    su_y_down = item_ey < item_sy;
    su_adx    = su_x_down ? (item_sx - item_ex) : (item_ex - item_sx);
    su_ady    = su_y_down ? (item_sy - item_ey) : (item_ey - item_sy);
    su_steep  = su_ady > su_adx;
    su_major  = su_steep ? su_ady : su_adx;
    su_minor  = su_steep ? su_adx : su_ady;
    // 2*minor - major, two's complement
    su_err    = {2'b00, su_minor, 1'b0} - {3'b000, su_major};
  end

  always_comb begin
    err_nonneg = !err_term[ERR_W-1];
    is_last    = (step_count + CNT_ONE) == major_len;
    err_next   = err_term - (err_nonneg ? {1'b0, major_len, 1'b0} : '0)
                 + {1'b0, minor_len, 1'b0};
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (steep) begin
      cur_y_next = move_coord(cur_y, y_down);
      if (err_nonneg) cur_x_next = move_coord(cur_x, x_down);
    end else begin
      cur_x_next = move_coord(cur_x, x_down);
      if (err_nonneg) cur_y_next = move_coord(cur_y, y_down);
    end
    dash_phase_next = (dash_phase == DASH_PERIOD - 4'd1) ? 4'd0 : dash_phase + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (do_start) begin
      active <= su_major != '0;
    end else if (do_step && is_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      cur_x       <= item_sx;
      cur_y       <= item_sy;
      err_term    <= su_err;
      major_len   <= {1'b0, su_major};
      minor_len   <= {1'b0, su_minor};
      step_count  <= '0;
      steep       <= su_steep;
      x_down      <= su_x_down;
      y_down      <= su_y_down;
      dash_phase  <= 4'd0;
      pen_color   <= item_color;
      line_dashed <= item_dashed;
    end else if (do_step) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      err_term   <= err_next;
      step_count <= step_count + CNT_ONE;
      dash_phase <= dash_phase_next;
    end
  end

  assign res_valid = do_step;
  assign res_x     = cur_x;
  assign res_y     = cur_y;
  assign res_color = pen_color;
  assign res_draw  = !line_dashed || (dash_phase <= DASH_ON_MAX);
  assign res_last  = is_last;

  assign status.active      = active;
  assign status.line_dashed = line_dashed;

endmodule

FILE: design/bls_out_reg.sv
module bls_out_reg #(
  parameter int unsigned DATA_W = 40
) (
  input  logic              clk,
  input  logic              rst,
  output logic              take,
  input  logic              load_valid,
  input  logic [DATA_W-1:0] load_data,
  input  logic              load_user,
  input  logic              load_last,
  output logic              valid,
  input  logic              ready,
  output logic [DATA_W-1:0] data,
  output logic              user,
  output logic              last
);

  // slot is free when empty or being drained this cycle
  assign take = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      data <= load_data;
      user <= load_user;
      last <= load_last;
    end
  end

endmodule

FILE: design/bresenham_line_pixel_stepper_core.sv
// Bresenham line stepper, one pixel per transfer.
// Input channel s_axis: tuser selects the item kind. A start item (tuser 0)
// loads endpoints, color and dash style and gives no output. A step item
// (tuser 1) gives one pixel of the active line; step items while no line is
// active are consumed and give nothing. A line of major length L gives L
// pixels from the start point up to, not including, the end point; equal
// endpoints give none. A start while a line runs drops the old line.
// Output channel m_axis: pixel column, row and color in tdata, draw flag in
// tuser (low for dash gaps), tlast on the final pixel of the line.
// A step accepted on s_axis is registered in the item register, worked on
// from there, and shows on m_axis once the output register takes it.
// Throughput: one item per clock while the output register is not held; the
// setup and step logic is combinational from item to output register.
// Reset (rst, synchronous) empties both registers and ends any line.
// When the receiver holds m_axis_tready low the output register keeps its
// pixel, the item register holds, and s_axis_tready drops once it is full.
`include "bresenham_line_pixel_stepper_core_macros.svh"

module bresenham_line_pixel_stepper_core #(
  parameter int unsigned COORD_BITS = 9
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, pixel_color, dashed, zero fill
  input  logic [((4*COORD_BITS+bls_pkg::COLOR_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_x, out_y, out_color, zero fill
  output logic [((2*COORD_BITS+bls_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // draw
  output logic m_axis_tuser,
  output logic m_axis_tlast
);
  import bls_pkg::*;

  localparam int unsigned OUT_W = ((2*COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int unsigned PIX_W = 2*COORD_BITS + COLOR_BITS;

  logic                  take;
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic [COLOR_BITS-1:0] res_color;
  logic                  res_draw;
  logic                  res_last;
  bls_status_t           status;
  logic [PIX_W-1:0]      pix_data;

  bls_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_mode    (s_axis_tuser),
    .in_start_x (s_axis_tdata[COORD_BITS-1:0]),
    .in_start_y (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_end_x   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_end_y   (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .in_color   (s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS]),
    .in_dashed  (s_axis_tdata[4*COORD_BITS+COLOR_BITS]),
    .take       (take),
    .res_valid  (res_valid),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_color  (res_color),
    .res_draw   (res_draw),
    .res_last   (res_last),
    .status     (status)
  );

  assign pix_data = {res_color, res_y, res_x};

  bls_out_reg #(
    .DATA_W(OUT_W)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .load_valid (res_valid),
    .load_data  (OUT_W'(pix_data)),
    .load_user  (res_draw),
    .load_last  (res_last),
    .valid      (m_axis_tvalid),
    .ready      (m_axis_tready),
    .data       (m_axis_tdata),
    .user       (m_axis_tuser),
    .last       (m_axis_tlast)
  );

  // the final pixel of a line ends it
  `BLS_ASSERT_NEXT(a_last_ends_line, clk, rst, take && res_valid && res_last, !status.active)
  // a dash gap can only come from a dashed line
  `BLS_ASSERT_NOW(a_gap_only_dashed, clk, rst, m_axis_tvalid && !m_axis_tuser, status.line_dashed)
  // input side only stalls behind a held output
  `BLS_ASSERT_NOW(a_stall_cause, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

FILE: dv/bresenham_line_pixel_stepper_core_checker.sv
`timescale 1ns / 100ps

module bresenham_line_pixel_stepper_core_checker #(
  parameter int unsigned COORD_BITS = 9
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  // start_x, start_y, end_x, end_y, pixel_color, dashed, zero fill
  input  logic [((4*COORD_BITS+bls_pkg::COLOR_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic s_axis_tuser,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_x, out_y, out_color, zero fill
  input  logic [((2*COORD_BITS+bls_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // draw
  input  logic m_axis_tuser,
  input  logic m_axis_tlast,
  output int   mismatch_count,
  output int   pending
);
  import bls_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned S_W   = ((4*CB+COLOR_BITS+1+7)/8)*8;
  localparam int unsigned ERR_W = CB + 3;

  typedef struct packed {
    logic [CB-1:0]         x;
    logic [CB-1:0]         y;
    logic [COLOR_BITS-1:0] color;
    logic                  draw;
    logic                  last;
  } pixel_t;

  pixel_t pixel_queue[$];

  // line walker state
  logic                    line_active;
  logic [CB-1:0]           cur_x, cur_y;
  logic signed [ERR_W-1:0] err_acc;
  logic [CB:0]             major_len, minor_len, step_count;
  logic                    steep, x_down, y_down;
  logic [3:0]              dash_phase;
  logic [COLOR_BITS-1:0]   pen_color;
  logic                    line_dashed;

  task automatic clear_line();
    line_active = 1'b0;
    cur_x       = '0;
    cur_y       = '0;
    err_acc     = '0;
    major_len   = '0;
    minor_len   = '0;
    step_count  = '0;
    steep       = 1'b0;
    x_down      = 1'b0;
    y_down      = 1'b0;
    dash_phase  = '0;
    pen_color   = '0;
    line_dashed = 1'b0;
  endtask

  task automatic load_line(input logic [S_W-1:0] d);
    logic [CB-1:0] x0, y0, x1, y1;
    logic [CB:0]   adx, ady;
    x0 = d[CB-1:0];
    y0 = d[2*CB-1:CB];
    x1 = d[3*CB-1:2*CB];
    y1 = d[4*CB-1:3*CB];
    x_down = x1 < x0;
    y_down = y1 < y0;
    adx = x_down ? x0 - x1 : x1 - x0;
    ady = y_down ? y0 - y1 : y1 - y0;
    steep = ady > adx;
    major_len = steep ? ady : adx;
    minor_len = steep ? adx : ady;
    err_acc = $signed({1'b0, minor_len, 1'b0}) - $signed({2'b00, major_len});
    cur_x = x0;
    cur_y = y0;
    step_count = '0;
    dash_phase = '0;
    pen_color = d[4*CB +: COLOR_BITS];
    line_dashed = d[4*CB+COLOR_BITS];
    line_active = major_len != 0;
  endtask

  // emit the current pixel, then walk one unit along the major axis
  task automatic advance_line();
    pixel_t px;
    px.x     = cur_x;
    px.y     = cur_y;
    px.color = pen_color;
    px.draw  = !line_dashed || dash_phase <= DASH_ON_MAX;
    px.last  = (step_count + 1'b1) == major_len;
    pixel_queue.push_back(px);
    if (err_acc >= 0) begin
      if (steep) cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
      else       cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
      err_acc = err_acc - $signed({1'b0, major_len, 1'b0});
    end
    if (steep) cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
    else       cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
    err_acc = err_acc + $signed({1'b0, minor_len, 1'b0});
    step_count = step_count + 1'b1;
    dash_phase = (dash_phase == DASH_PERIOD - 1'b1) ? 4'd0 : dash_phase + 1'b1;
    if (px.last) line_active = 1'b0;
  endtask

  task automatic check_pixel();
    pixel_t got, want;
    got.x     = m_axis_tdata[CB-1:0];
    got.y     = m_axis_tdata[2*CB-1:CB];
    got.color = m_axis_tdata[2*CB +: COLOR_BITS];
    got.draw  = m_axis_tuser;
    got.last  = m_axis_tlast;
    if (pixel_queue.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t unexpected pixel: x=%0d y=%0d color=%h draw=%b last=%b",
                 $realtime, got.x, got.y, got.color, got.draw, got.last);
    end else begin
      want = pixel_queue.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t pixel mismatch: exp %0d,%0d %h %b %b got %0d,%0d %h %b %b",
                   $realtime, want.x, want.y, want.color, want.draw, want.last,
                   got.x, got.y, got.color, got.draw, got.last);
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending = 0;
    clear_line();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      pixel_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_pixel();
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_START) load_line(s_axis_tdata);
        else if (line_active) advance_line();
      end
    end
    pending = pixel_queue.size();
  end

endmodule

FILE: dv/bresenham_line_pixel_stepper_core_tb.sv
`timescale 1ns / 100ps

module bresenham_line_pixel_stepper_core_tb;
  import bls_pkg::*;

  localparam int unsigned CB   = 9;
  localparam int unsigned S_W  = ((4*CB+COLOR_BITS+1+7)/8)*8;
  localparam int unsigned M_W  = ((2*CB+COLOR_BITS+7)/8)*8;
  localparam int          CMAX = (1 << CB) - 1;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_axis_tvalid, s_axis_tready;
  logic [S_W-1:0] s_axis_tdata;
  logic           s_axis_tuser;
  logic           m_axis_tvalid, m_axis_tready;
  logic [M_W-1:0] m_axis_tdata;
  logic           m_axis_tuser, m_axis_tlast;
  int             mismatch_count, pending;

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int line_items = 0;

  bresenham_line_pixel_stepper_core #(.COORD_BITS(CB)) dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  bresenham_line_pixel_stepper_core_checker #(.COORD_BITS(CB)) line_checker (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .mismatch_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [S_W-1:0] pack_line(input int x0, y0, x1, y1,
                                               input logic [15:0] color,
                                               input bit dashed);
    logic [S_W-1:0] d;
    d = '0;
    d[CB-1:0]               = x0[CB-1:0];
    d[2*CB-1:CB]            = y0[CB-1:0];
    d[3*CB-1:2*CB]          = x1[CB-1:0];
    d[4*CB-1:3*CB]          = y1[CB-1:0];
    d[4*CB +: COLOR_BITS]   = color;
    d[4*CB+COLOR_BITS]      = dashed;
    return d;
  endfunction

  function automatic logic [S_W-1:0] noise_fields();
    return pack_line($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                     $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                     16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_item(input logic mode, input logic [S_W-1:0] d);
    int gap;
    if ($urandom_range(0, 99) == 0) tx_burst = ($urandom_range(0, 2) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
  endtask

  // start a line, then give it n_steps advance transfers with junk in the fields
  task automatic draw_line(input int x0, y0, x1, y1, input logic [15:0] color,
                           input bit dashed, input int n_steps);
    int dx, dy, major;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    major = (dy > dx) ? dy : dx;
    send_item(MODE_START, pack_line(x0, y0, x1, y1, color, dashed));
    for (int i = 0; i < n_steps; i++) send_item(MODE_STEP, noise_fields());
    line_items += 1 + ((n_steps < major) ? n_steps : major);
  endtask

  function automatic int near_coord(input int c);
    int d, e;
    d = $urandom_range(0, 48) - 24;
    e = c + d;
    if (e < 0 || e > CMAX) e = c - d;
    return e;
  endfunction

  // receiver: per pixel, a random stall before taking it
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 79) == 0) rx_burst = ($urandom_range(0, 2) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  initial begin
    int x0, y0, x1, y1, kind, major, n;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_START;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle advance, zero length, corner-to-corner tie restarted
    // mid-line, shallow, steep backwards, dashed into the gap
    send_item(MODE_STEP, noise_fields());
    draw_line(CMAX, CMAX, CMAX, CMAX, 16'hffff, 1'b1, 1);
    draw_line(0, 0, CMAX, CMAX, 16'h0000, 1'b0, 3);
    draw_line(10, 5, 12, 5, 16'hf800, 1'b0, 3);
    draw_line(20, 30, 18, 27, 16'h07e0, 1'b0, 3);
    draw_line(100, 100, 93, 103, 16'h001f, 1'b1, 7);

    // random lines, mostly short, sometimes cut short by a new start
    while (line_items < 2000) begin
      kind = $urandom_range(0, 99);
      x0 = $urandom_range(0, CMAX);
      y0 = $urandom_range(0, CMAX);
      if (kind < 4) begin
        draw_line(x0, y0, x0, y0, 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 2));
      end else if (kind < 8) begin
        send_item(MODE_STEP, noise_fields());
      end else begin
        if ($urandom_range(0, 59) == 0) begin
          x1 = $urandom_range(0, CMAX);
          y1 = $urandom_range(0, CMAX);
        end else begin
          x1 = near_coord(x0);
          y1 = near_coord(y0);
          if ($urandom_range(0, 7) == 0) y1 = y0;
          else if ($urandom_range(0, 7) == 0) x1 = x0;
        end
        major = (x1 > x0 ? x1 - x0 : x0 - x1);
        if ((y1 > y0 ? y1 - y0 : y0 - y1) > major) major = (y1 > y0 ? y1 - y0 : y0 - y1);
        n = major;
        if (major > 0 && $urandom_range(0, 6) == 0) n = $urandom_range(0, major - 1);
        else if ($urandom_range(0, 4) == 0) n = major + $urandom_range(1, 2);
        draw_line(x0, y0, x1, y1, 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), n);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("bresenham_line_pixel_stepper_core_tb: PASS");
    end else begin
      $display("bresenham_line_pixel_stepper_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bresenham_line_pixel_stepper_core_tb: FAIL");
    $finish;
  end

endmodule

FILE: bresenham_line_pixel_stepper_core.f
+incdir+design
design/bls_pkg.sv
design/bls_step.sv
design/bls_out_reg.sv
design/bresenham_line_pixel_stepper_core.sv
dv/bresenham_line_pixel_stepper_core_checker.sv
dv/bresenham_line_pixel_stepper_core_tb.sv
